// ===== design/acfp_pkg.sv =====
// acfp_pkg: shared constants, codes and the result record of the ASCII command frame parser.
// Used by the top, parser, queue and sequencer modules and by the bench; depends on nothing.
`timescale 1ns / 1ps

package acfp_pkg;

	// Field limits
	localparam int MAX_FIELD     = 32;
	localparam int PAYLOAD_DEPTH = 32;
	localparam int PAY_AW        = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int LEN_W         = 6;
	localparam int CELL_COUNT    = 4;

	// Decoupling queue between the parser and the result sequencer
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEN_W-1:0] FIELD_LAST = LEN_W'(MAX_FIELD - 1);
	localparam logic [LEN_W-1:0] PAY_LIMIT  = LEN_W'(PAYLOAD_DEPTH);
	localparam logic [LEN_W-1:0] CELL_LAST  = LEN_W'(CELL_COUNT - 1);

	// Characters of the command stream
	localparam logic [7:0] CH_START = 8'h24;  // '$'
	localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
	localparam logic [7:0] CH_END   = 8'h3A;  // ':'
	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] ACC_BIAS = 8'd208;  // minus '0' modulo 256

	// Cell codes
	localparam logic [1:0] CELL_FREE     = 2'd0;
	localparam logic [1:0] CELL_OBSTACLE = 2'd1;
	localparam logic [1:0] CELL_KEY      = 2'd2;

	// Direction codes
	localparam logic [3:0] DIR_E       = 4'd0;
	localparam logic [3:0] DIR_W       = 4'd1;
	localparam logic [3:0] DIR_S       = 4'd2;
	localparam logic [3:0] DIR_N       = 4'd3;
	localparam logic [3:0] DIR_SE      = 4'd4;
	localparam logic [3:0] DIR_NE      = 4'd5;
	localparam logic [3:0] DIR_SW      = 4'd6;
	localparam logic [3:0] DIR_NW      = 4'd7;
	localparam logic [3:0] DIR_K       = 4'd8;
	localparam logic [3:0] DIR_UNKNOWN = 4'd9;

	typedef enum logic [2:0] {
		KIND_GO        = 3'd0,
		KIND_RESP      = 3'd1,
		KIND_ALERT     = 3'd2,
		KIND_PAYLOAD   = 3'd3,
		KIND_MALFORMED = 3'd4
	} kind_t;

	// One result record; also the queue entry
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       pos_x;
		logic [7:0]       pos_y;
		logic [7:0]       rotation;
		logic [7:0]       cells;
		logic [3:0]       direction;
		logic [7:0]       alert_id;
		logic [LEN_W-1:0] payload_len;
		logic [7:0]       payload_byte;
		logic             last;
	} result_t;

endpackage

// ===== design/acfp_rx_if.sv =====
// acfp_rx_if: valid/ready channel carrying one received byte per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface acfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/acfp_res_if.sv =====
// acfp_res_if: valid/ready channel carrying one parser result per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface acfp_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [7:0] rotation;
	logic [7:0] cells;
	logic [3:0] direction;
	logic [7:0] alert_id;
	logic [5:0] payload_len;
	logic [7:0] payload_byte;
	logic       last;

	modport source (output valid, output kind, output pos_x, output pos_y, output rotation,
		output cells, output direction, output alert_id, output payload_len,
		output payload_byte, output last, input ready);
	modport sink (input valid, input kind, input pos_x, input pos_y, input rotation,
		input cells, input direction, input alert_id, input payload_len,
		input payload_byte, input last, output ready);
endinterface

// ===== design/ascii_command_frame_parser_top.sv =====
// ascii_command_frame_parser_top: top level of the ASCII command frame parser.
// Depends on acfp_pkg, acfp_rx_if, acfp_res_if, acfp_front, acfp_queue, acfp_back, acfp_ram.
`timescale 1ns / 1ps

// Parses '$'-framed ASCII commands ending in ':' from a byte stream and emits GO, response,
// alert header, alert payload and malformed-frame results. The parser front end takes one
// byte per clock while the queue has room and no alert is draining; finished results pass
// through a two-entry queue to a sequencer that owns the output register, so a stalled
// output only holds the input once that queue is full. After the ':' of an alert frame the
// input stalls until the header and all payload bytes have been handed to the output
// register, each byte by a registered read of the 32-byte payload RAM. The RAM needs no
// clearing after reset; only bytes written in the current frame are read back.

module ascii_command_frame_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	acfp_rx_if.sink    rx,
	acfp_res_if.source res
);

	logic                         push;
	acfp_pkg::result_t            push_data;
	logic                         pop;
	acfp_pkg::result_t            pop_data;
	logic                         q_full;
	logic                         q_empty;
	logic                         drain_done;
	logic                         busy;
	logic                         ram_we;
	logic [acfp_pkg::PAY_AW-1:0]  ram_waddr;
	logic [7:0]                   ram_wdata;
	logic                         ram_re;
	logic [acfp_pkg::PAY_AW-1:0]  ram_raddr;
	logic [7:0]                   ram_rdata;

	// Parser
	acfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.q_full     (q_full),
		.drain_done (drain_done),
		.push       (push),
		.push_data  (push_data),
		.busy       (busy),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	// Result queue
	acfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Alert payload store
	acfp_ram #(
		.WIDTH (8),
		.DEPTH (acfp_pkg::PAYLOAD_DEPTH)
	) u_pay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result sequencer
	acfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (pop_data),
		.pop        (pop),
		.drain_done (drain_done),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.res        (res)
	);

	// Drain completion only ends a stall the parser is actually in
	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done |-> busy)
		else $error("drain completion without pending alert");

endmodule

// ===== design/acfp_ram.sv =====
// acfp_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module acfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/acfp_front.sv =====
// acfp_front: byte-level frame parser. Accepts received bytes, tracks the frame phase,
// stores alert payload bytes in the RAM and pushes finished results into the queue.
// Depends on acfp_pkg and acfp_rx_if.
`timescale 1ns / 1ps

module acfp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	acfp_rx_if.sink                      rx,
	input  logic                         q_full,
	input  logic                         drain_done,
	output logic                         push,
	output acfp_pkg::result_t            push_data,
	output logic                         busy,
	output logic                         ram_we,
	output logic [acfp_pkg::PAY_AW-1:0]  ram_waddr,
	output logic [7:0]                   ram_wdata
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_TYPE,
		PH_G,
		PH_GOEND,
		PH_DX,
		PH_DY,
		PH_DROT,
		PH_CELLS,
		PH_DIR,
		PH_AID,
		PH_APAY,
		PH_DROP
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic [7:0]                   acc_q, acc_d;
	logic [acfp_pkg::LEN_W-1:0]   fcnt_q, fcnt_d;
	logic [7:0]                   x_q, x_d;
	logic [7:0]                   y_q, y_d;
	logic [7:0]                   rot_q, rot_d;
	logic [7:0]                   cells_q, cells_d;
	logic [7:0]                   tok0_q, tok0_d;
	logic [7:0]                   tok1_q, tok1_d;
	logic [acfp_pkg::LEN_W-1:0]   toklen_q, toklen_d;
	logic [7:0]                   aid_q, aid_d;
	logic [acfp_pkg::LEN_W-1:0]   paycnt_q, paycnt_d;
	logic                         busy_q, busy_d;

	logic       take;
	logic [7:0] b;
	logic [7:0] acc_next;
	logic [1:0] cell_code;

	// Direction token lookup
	function automatic logic [3:0] dir_decode(input logic [acfp_pkg::LEN_W-1:0] len,
		input logic [7:0] c0, input logic [7:0] c1);
		logic [3:0] d;
		d = acfp_pkg::DIR_UNKNOWN;
		if (len == '0) begin
			d = acfp_pkg::DIR_E;
		end else if (len == acfp_pkg::LEN_W'(1)) begin
			if (c0 == acfp_pkg::CH_E) d = acfp_pkg::DIR_E;
			else if (c0 == acfp_pkg::CH_W) d = acfp_pkg::DIR_W;
			else if (c0 == acfp_pkg::CH_S) d = acfp_pkg::DIR_S;
			else if (c0 == acfp_pkg::CH_N) d = acfp_pkg::DIR_N;
			else if (c0 == acfp_pkg::CH_K) d = acfp_pkg::DIR_K;
		end else if (len == acfp_pkg::LEN_W'(2)) begin
			if (c0 == acfp_pkg::CH_S && c1 == acfp_pkg::CH_E) d = acfp_pkg::DIR_SE;
			else if (c0 == acfp_pkg::CH_N && c1 == acfp_pkg::CH_E) d = acfp_pkg::DIR_NE;
			else if (c0 == acfp_pkg::CH_S && c1 == acfp_pkg::CH_W) d = acfp_pkg::DIR_SW;
			else if (c0 == acfp_pkg::CH_N && c1 == acfp_pkg::CH_W) d = acfp_pkg::DIR_NW;
		end
		return d;
	endfunction

	// Handshake: hold off while the queue is full or an alert payload is draining
	assign rx.ready = !q_full && !busy_q;
	assign take     = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign busy     = busy_q;

	// Decimal accumulate: acc * 10 + (b - '0), all modulo 256
	assign acc_next = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + b + acfp_pkg::ACC_BIAS;

	always_comb begin
		if (b == acfp_pkg::CH_ZERO) cell_code = acfp_pkg::CELL_FREE;
		else if (b == acfp_pkg::CH_ONE) cell_code = acfp_pkg::CELL_OBSTACLE;
		else cell_code = acfp_pkg::CELL_KEY;
	end

	// Next-state logic of the parser
	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		fcnt_d    = fcnt_q;
		x_d       = x_q;
		y_d       = y_q;
		rot_d     = rot_q;
		cells_d   = cells_q;
		tok0_d    = tok0_q;
		tok1_d    = tok1_q;
		toklen_d  = toklen_q;
		aid_d     = aid_q;
		paycnt_d  = paycnt_q;
		busy_d    = busy_q && !drain_done;
		push      = 1'b0;
		push_data = '0;
		push_data.kind = acfp_pkg::KIND_MALFORMED;
		push_data.last = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = paycnt_q[acfp_pkg::PAY_AW-1:0];
		ram_wdata = b;

		if (take) begin
			if (b == acfp_pkg::CH_START) begin
				phase_d = PH_TYPE;
				acc_d   = '0;
				fcnt_d  = '0;
			end else begin
				case (phase_q)
					PH_TYPE: begin
						acc_d  = '0;
						fcnt_d = '0;
						if (b == acfp_pkg::CH_G) phase_d = PH_G;
						else if (b == acfp_pkg::CH_D) phase_d = PH_DX;
						else if (b == acfp_pkg::CH_A) phase_d = PH_AID;
						else if (b == acfp_pkg::CH_END) phase_d = PH_IDLE;
						else phase_d = PH_DROP;
					end
					PH_G: begin
						if (b == acfp_pkg::CH_O) phase_d = PH_GOEND;
						else if (b == acfp_pkg::CH_END) phase_d = PH_IDLE;
						else phase_d = PH_DROP;
					end
					PH_GOEND: begin
						if (b == acfp_pkg::CH_END) begin
							phase_d        = PH_IDLE;
							push           = 1'b1;
							push_data.kind = acfp_pkg::KIND_GO;
						end
					end
					PH_DX, PH_DY, PH_DROT, PH_AID: begin
						if (b == acfp_pkg::CH_END) begin
							// frame ended inside a decimal field
							phase_d = PH_IDLE;
							push    = 1'b1;
						end else if (b == acfp_pkg::CH_COMMA) begin
							acc_d  = '0;
							fcnt_d = '0;
							case (phase_q)
								PH_DX: begin
									x_d     = acc_q;
									phase_d = PH_DY;
								end
								PH_DY: begin
									y_d     = acc_q;
									phase_d = PH_DROT;
								end
								PH_DROT: begin
									rot_d   = acc_q;
									cells_d = '0;
									phase_d = PH_CELLS;
								end
								default: begin
									aid_d    = acc_q;
									paycnt_d = '0;
									phase_d  = PH_APAY;
								end
							endcase
						end else if (fcnt_q >= acfp_pkg::FIELD_LAST) begin
							phase_d = PH_DROP;
							push    = 1'b1;
						end else begin
							acc_d  = acc_next;
							fcnt_d = fcnt_q + acfp_pkg::LEN_W'(1);
						end
					end
					PH_CELLS: begin
						if (b == acfp_pkg::CH_END) begin
							phase_d = PH_IDLE;
							push    = 1'b1;
						end else begin
							cells_d = {cells_q[5:0], cell_code};
							fcnt_d  = fcnt_q + acfp_pkg::LEN_W'(1);
							if (fcnt_q >= acfp_pkg::CELL_LAST) begin
								phase_d  = PH_DIR;
								tok0_d   = '0;
								tok1_d   = '0;
								toklen_d = '0;
							end
						end
					end
					PH_DIR: begin
						if (b == acfp_pkg::CH_END) begin
							phase_d             = PH_IDLE;
							push                = 1'b1;
							push_data.kind      = acfp_pkg::KIND_RESP;
							push_data.pos_x     = x_q;
							push_data.pos_y     = y_q;
							push_data.rotation  = rot_q;
							push_data.cells     = cells_q;
							push_data.direction = dir_decode(toklen_q, tok0_q, tok1_q);
						end else if (toklen_q >= acfp_pkg::FIELD_LAST) begin
							phase_d = PH_DROP;
							push    = 1'b1;
						end else begin
							if (toklen_q == '0) tok0_d = b;
							else if (toklen_q == acfp_pkg::LEN_W'(1)) tok1_d = b;
							toklen_d = toklen_q + acfp_pkg::LEN_W'(1);
						end
					end
					PH_APAY: begin
						if (b == acfp_pkg::CH_END) begin
							// header goes out; payload is read back from the RAM
							phase_d               = PH_IDLE;
							push                  = 1'b1;
							push_data.kind        = acfp_pkg::KIND_ALERT;
							push_data.alert_id    = aid_q;
							push_data.payload_len = paycnt_q;
							push_data.last        = (paycnt_q == '0);
							busy_d                = 1'b1;
						end else if (paycnt_q >= acfp_pkg::PAY_LIMIT) begin
							phase_d = PH_DROP;
							push    = 1'b1;
						end else begin
							ram_we   = 1'b1;
							paycnt_d = paycnt_q + acfp_pkg::LEN_W'(1);
						end
					end
					PH_DROP: begin
						if (b == acfp_pkg::CH_END) phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			acc_q    <= '0;
			fcnt_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
			rot_q    <= '0;
			cells_q  <= '0;
			tok0_q   <= '0;
			tok1_q   <= '0;
			toklen_q <= '0;
			aid_q    <= '0;
			paycnt_q <= '0;
			busy_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			fcnt_q   <= fcnt_d;
			x_q      <= x_d;
			y_q      <= y_d;
			rot_q    <= rot_d;
			cells_q  <= cells_d;
			tok0_q   <= tok0_d;
			tok1_q   <= tok1_d;
			toklen_q <= toklen_d;
			aid_q    <= aid_d;
			paycnt_q <= paycnt_d;
			busy_q   <= busy_d;
		end
	end

	// An alert header always leaves the parser stalled until its payload drains
	a_alert_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_data.kind == acfp_pkg::KIND_ALERT |=> busy_q)
		else $error("alert pushed without entering drain stall");

	// Payload is never written while a previous payload is being read back
	a_no_write_while_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !busy_q && phase_q == PH_APAY)
		else $error("payload RAM written during drain");

endmodule

// ===== design/acfp_queue.sv =====
// acfp_queue: small FIFO of finished result records between parser and sequencer.
// Depends on acfp_pkg.
`timescale 1ns / 1ps

module acfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  acfp_pkg::result_t push_data,
	input  logic              pop,
	output acfp_pkg::result_t pop_data,
	output logic              full,
	output logic              empty
);

	acfp_pkg::result_t            entry_q [acfp_pkg::QUEUE_DEPTH];
	logic [acfp_pkg::QPTR_W-1:0]  wptr_q;
	logic [acfp_pkg::QPTR_W-1:0]  rptr_q;
	logic [acfp_pkg::QCNT_W-1:0]  count_q;

	function automatic logic [acfp_pkg::QPTR_W-1:0] ptr_inc(
		input logic [acfp_pkg::QPTR_W-1:0] p);
		logic [acfp_pkg::QPTR_W-1:0] n;
		if (p == acfp_pkg::QPTR_W'(acfp_pkg::QUEUE_DEPTH - 1)) n = '0;
		else n = p + acfp_pkg::QPTR_W'(1);
		return n;
	endfunction

	assign full     = (count_q == acfp_pkg::QCNT_W'(acfp_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= ptr_inc(wptr_q);
			if (pop) rptr_q <= ptr_inc(rptr_q);
			if (push && !pop) count_q <= count_q + acfp_pkg::QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - acfp_pkg::QCNT_W'(1);
		end
	end

	// Overflow or underflow would lose or invent a result
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("result queue overflow or underflow");

endmodule

// ===== design/acfp_back.sv =====
// acfp_back: result sequencer. Pops queued records into the output register and expands
// an alert header into its payload bytes read back from the payload RAM.
// Depends on acfp_pkg and acfp_res_if.
`timescale 1ns / 1ps

module acfp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  acfp_pkg::result_t            q_data,
	output logic                         pop,
	output logic                         drain_done,
	output logic                         ram_re,
	output logic [acfp_pkg::PAY_AW-1:0]  ram_raddr,
	input  logic [7:0]                   ram_rdata,
	acfp_res_if.source                   res
);

	typedef enum logic [1:0] {
		BK_CMD,
		BK_READ,
		BK_LOAD
	} bk_state_t;

	bk_state_t                    st_q;
	acfp_pkg::result_t            res_q;
	acfp_pkg::result_t            hdr_q;
	logic                         vld_q;
	logic [acfp_pkg::LEN_W-1:0]   idx_q;

	logic              slot_free;
	logic              last_byte;
	logic              hdr_only;
	logic              pay_load;
	acfp_pkg::result_t pay_rec;

	assign slot_free = !vld_q || res.ready;
	assign last_byte = (idx_q + acfp_pkg::LEN_W'(1)) == hdr_q.payload_len;
	assign hdr_only  = q_data.kind == acfp_pkg::KIND_ALERT && q_data.payload_len == '0;
	assign pay_load  = (st_q == BK_LOAD) && slot_free;

	assign pop        = (st_q == BK_CMD) && !q_empty && slot_free;
	assign ram_re     = (st_q == BK_READ);
	assign ram_raddr  = idx_q[acfp_pkg::PAY_AW-1:0];
	assign drain_done = (pop && hdr_only) || (st_q == BK_LOAD && slot_free && last_byte);

	// Payload byte record built from the saved header
	always_comb begin
		pay_rec              = hdr_q;
		pay_rec.kind         = acfp_pkg::KIND_PAYLOAD;
		pay_rec.payload_byte = ram_rdata;
		pay_rec.last         = last_byte;
	end

	// Output channel
	assign res.valid        = vld_q;
	assign res.kind         = res_q.kind;
	assign res.pos_x        = res_q.pos_x;
	assign res.pos_y        = res_q.pos_y;
	assign res.rotation     = res_q.rotation;
	assign res.cells        = res_q.cells;
	assign res.direction    = res_q.direction;
	assign res.alert_id     = res_q.alert_id;
	assign res.payload_len  = res_q.payload_len;
	assign res.payload_byte = res_q.payload_byte;
	assign res.last         = res_q.last;

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= BK_CMD;
			res_q <= '0;
			hdr_q <= '0;
			vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (pop || pay_load) vld_q <= 1'b1;
			else if (res.ready) vld_q <= 1'b0;
			case (st_q)
				BK_CMD: begin
					if (pop) begin
						res_q <= q_data;
						if (q_data.kind == acfp_pkg::KIND_ALERT && !hdr_only) begin
							hdr_q <= q_data;
							idx_q <= '0;
							st_q  <= BK_READ;
						end
					end
				end
				BK_READ: begin
					st_q <= BK_LOAD;
				end
				BK_LOAD: begin
					if (slot_free) begin
						res_q <= pay_rec;
						idx_q <= idx_q + acfp_pkg::LEN_W'(1);
						st_q  <= last_byte ? BK_CMD : BK_READ;
					end
				end
				default: begin
					st_q <= BK_CMD;
				end
			endcase
		end
	end

	// Payload reads stay inside the bytes stored for this frame
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != BK_CMD |-> idx_q < hdr_q.payload_len)
		else $error("payload index past stored length");

	// A payload byte result always belongs to a non-empty payload
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && res_q.kind == acfp_pkg::KIND_PAYLOAD |-> res_q.payload_len != '0)
		else $error("payload byte emitted for empty payload");

endmodule

// ===== dv/ascii_command_frame_parser_top_test.sv =====
// ascii_command_frame_parser_top_test: self-checking bench for the ASCII command frame parser.
// Depends on acfp_pkg, acfp_rx_if, acfp_res_if and ascii_command_frame_parser_top.
`timescale 1ns / 1ps

module ascii_command_frame_parser_top_test;
	import acfp_pkg::*;

	// Parse phases of the frame tracker
	typedef enum logic [3:0] {
		ST_IDLE, ST_TYPE, ST_G, ST_GOEND, ST_DX, ST_DY, ST_DROT,
		ST_CELLS, ST_DIR, ST_AID, ST_APAY, ST_DROP
	} parse_phase_t;

	typedef struct {
		logic [7:0] data;
		bit         hold;  // wait for all due results before sending
	} tx_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	acfp_rx_if  rx_ch();
	acfp_res_if res_ch();

	ascii_command_frame_parser_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	always #1 clk = ~clk;

	tx_item_t tx_bytes[$];
	result_t  due_results[$];
	bit       hold_next = 1'b0;
	int       n_fed = 0;
	int       n_frames = 0;
	int       n_predicted = 0;
	int       n_checked = 0;
	int       n_errors = 0;
	int       kind_seen[5] = '{default: 0};

	string dir_words[10] = '{"E", "W", "S", "N", "SE", "NE", "SW", "NW", "K", ""};

	// Frame tracker state
	parse_phase_t m_phase = ST_IDLE;
	logic [7:0]   m_acc = '0;
	logic [5:0]   m_cnt = '0;
	logic [7:0]   m_x = '0, m_y = '0, m_rot = '0, m_cells = '0;
	logic [7:0]   m_tok0 = '0, m_tok1 = '0;
	logic [5:0]   m_tok_len = '0;
	logic [7:0]   m_id = '0;
	logic [7:0]   m_pay[$];

	function automatic void expect_flag(kind_t k);
		result_t r;
		r = '0;
		r.kind = k;
		r.last = 1'b1;
		due_results.push_back(r);
		n_predicted++;
	endfunction

	function automatic logic [3:0] token_dir();
		if (m_tok_len == 0)
			return DIR_E;
		if (m_tok_len == 1) begin
			case (m_tok0)
				CH_E: return DIR_E;
				CH_W: return DIR_W;
				CH_S: return DIR_S;
				CH_N: return DIR_N;
				CH_K: return DIR_K;
				default: return DIR_UNKNOWN;
			endcase
		end
		if (m_tok_len == 2) begin
			if (m_tok0 == CH_S && m_tok1 == CH_E) return DIR_SE;
			if (m_tok0 == CH_N && m_tok1 == CH_E) return DIR_NE;
			if (m_tok0 == CH_S && m_tok1 == CH_W) return DIR_SW;
			if (m_tok0 == CH_N && m_tok1 == CH_W) return DIR_NW;
		end
		return DIR_UNKNOWN;
	endfunction

	// Advance the frame tracker by one accepted byte and queue what it produces
	function automatic void track_byte(logic [7:0] b);
		result_t r;
		logic [1:0] code;
		if (b == CH_START) begin
			m_phase = ST_TYPE;
			m_acc = '0;
			m_cnt = '0;
			return;
		end
		case (m_phase)
			ST_TYPE: begin
				m_acc = '0;
				m_cnt = '0;
				if (b == CH_G) m_phase = ST_G;
				else if (b == CH_D) m_phase = ST_DX;
				else if (b == CH_A) m_phase = ST_AID;
				else if (b == CH_END) m_phase = ST_IDLE;
				else m_phase = ST_DROP;
			end
			ST_G: m_phase = (b == CH_O) ? ST_GOEND : ((b == CH_END) ? ST_IDLE : ST_DROP);
			ST_GOEND: begin
				if (b == CH_END) begin
					m_phase = ST_IDLE;
					expect_flag(KIND_GO);
				end
			end
			ST_DX, ST_DY, ST_DROT, ST_AID: begin
				if (b == CH_END) begin
					m_phase = ST_IDLE;
					expect_flag(KIND_MALFORMED);
				end else if (b == CH_COMMA) begin
					case (m_phase)
						ST_DX: begin m_x = m_acc; m_phase = ST_DY; end
						ST_DY: begin m_y = m_acc; m_phase = ST_DROT; end
						ST_DROT: begin m_rot = m_acc; m_phase = ST_CELLS; m_cells = '0; end
						default: begin m_id = m_acc; m_phase = ST_APAY; m_pay.delete(); end
					endcase
					m_acc = '0;
					m_cnt = '0;
				end else if (m_cnt + 1 >= MAX_FIELD) begin
					m_phase = ST_DROP;
					expect_flag(KIND_MALFORMED);
				end else begin
					m_acc = m_acc * 8'd10 + b + ACC_BIAS;
					m_cnt = m_cnt + 6'd1;
				end
			end
			ST_CELLS: begin
				if (b == CH_END) begin
					m_phase = ST_IDLE;
					expect_flag(KIND_MALFORMED);
				end else begin
					if (b == CH_ZERO) code = CELL_FREE;
					else if (b == CH_ONE) code = CELL_OBSTACLE;
					else code = CELL_KEY;
					m_cells = {m_cells[5:0], code};
					m_cnt = m_cnt + 6'd1;
					if (m_cnt >= 4) begin
						m_phase = ST_DIR;
						m_tok0 = '0;
						m_tok1 = '0;
						m_tok_len = '0;
					end
				end
			end
			ST_DIR: begin
				if (b == CH_END) begin
					r = '0;
					r.kind = KIND_RESP;
					r.pos_x = m_x;
					r.pos_y = m_y;
					r.rotation = m_rot;
					r.cells = m_cells;
					r.direction = token_dir();
					r.last = 1'b1;
					due_results.push_back(r);
					n_predicted++;
					m_phase = ST_IDLE;
				end else if (m_tok_len + 1 >= MAX_FIELD) begin
					m_phase = ST_DROP;
					expect_flag(KIND_MALFORMED);
				end else begin
					if (m_tok_len == 0) m_tok0 = b;
					else if (m_tok_len == 1) m_tok1 = b;
					m_tok_len = m_tok_len + 6'd1;
				end
			end
			ST_APAY: begin
				if (b == CH_END) begin
					r = '0;
					r.kind = KIND_ALERT;
					r.alert_id = m_id;
					r.payload_len = LEN_W'(m_pay.size());
					r.last = (m_pay.size() == 0);
					due_results.push_back(r);
					n_predicted++;
					for (int k = 0; k < m_pay.size(); k++) begin
						r.kind = KIND_PAYLOAD;
						r.payload_byte = m_pay[k];
						r.last = (k == m_pay.size() - 1);
						due_results.push_back(r);
						n_predicted++;
					end
					m_phase = ST_IDLE;
				end else if (m_pay.size() >= PAYLOAD_DEPTH) begin
					m_phase = ST_DROP;
					expect_flag(KIND_MALFORMED);
				end else
					m_pay.push_back(b);
			end
			ST_DROP: if (b == CH_END) m_phase = ST_IDLE;
			default: m_phase = ST_IDLE;
		endcase
	endfunction

	// Stimulus building
	task automatic put(logic [7:0] b);
		tx_bytes.push_back('{data: b, hold: hold_next});
		hold_next = 1'b0;
		n_fed++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_digits(int n);
		for (int i = 0; i < n; i++)
			put(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// Random byte that neither starts nor ends a frame
	function automatic logic [7:0] any_plain(bit no_comma);
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == CH_START || b == CH_END || (no_comma && b == CH_COMMA));
		return b;
	endfunction

	task automatic put_number();
		int c;
		c = $urandom_range(0, 19);
		if (c < 12)
			put_text($sformatf("%0d", $urandom_range(0, 999)));
		else if (c < 14)
			;  // empty field
		else if (c < 17)
			repeat ($urandom_range(1, 3)) put(any_plain(1'b1));
		else if (c < 19)
			put_digits(MAX_FIELD - 1);
		else
			put_digits(MAX_FIELD + $urandom_range(0, 2));
	endtask

	task automatic put_cells();
		repeat (4) begin
			case ($urandom_range(0, 5))
				0, 1: put(CH_ZERO);
				2, 3: put(CH_ONE);
				4: put(any_plain(1'b0));
				default: put(CH_K);
			endcase
		end
	endtask

	task automatic put_token();
		int c;
		c = $urandom_range(0, 19);
		if (c < 12)
			put_text(dir_words[$urandom_range(0, 9)]);
		else if (c < 18)
			repeat ($urandom_range(1, 3)) put(any_plain(1'b0));
		else if (c == 18)
			repeat (MAX_FIELD - 1) put(any_plain(1'b0));
		else
			repeat (MAX_FIELD + $urandom_range(0, 2)) put(any_plain(1'b0));
	endtask

	task automatic put_payload();
		int c, n;
		c = $urandom_range(0, 29);
		if (c < 24) n = $urandom_range(0, 6);
		else if (c < 27) n = $urandom_range(7, PAYLOAD_DEPTH);
		else if (c == 27) n = PAYLOAD_DEPTH;
		else n = PAYLOAD_DEPTH + $urandom_range(1, 3);
		repeat (n) put(any_plain(1'b0));
	endtask

	task automatic put_d_frame();
		put_text("$D");
		put_number(); put(CH_COMMA);
		put_number(); put(CH_COMMA);
		put_number(); put(CH_COMMA);
		put_cells();
		put_token();
		put(CH_END);
	endtask

	// One random frame: mostly well formed, some broken, some line noise
	task automatic put_frame();
		int c;
		logic [7:0] t;
		c = $urandom_range(0, 99);
		n_frames++;
		if (c < 15) begin
			put_text("$GO");
			repeat ($urandom_range(0, 3)) put(any_plain(1'b0));
			put(CH_END);
		end else if (c < 50)
			put_d_frame();
		else if (c < 75) begin
			put_text("$A");
			put_number();
			put(CH_COMMA);
			put_payload();
			put(CH_END);
		end else if (c < 80) begin
			do
				t = 8'($urandom);
			while (t == CH_G || t == CH_D || t == CH_A || t == CH_START);
			put(CH_START);
			put(t);
			repeat ($urandom_range(0, 3)) put(any_plain(1'b0));
			put(CH_END);
		end else if (c < 85) begin
			put_text("$G");
			do
				t = any_plain(1'b0);
			while (t == CH_O);
			put(t);
			repeat ($urandom_range(0, 2)) put(any_plain(1'b0));
			put(CH_END);
		end else if (c < 92) begin
			// D frame cut short by an early end or by a new start
			put_text("$D");
			put_number();
			if ($urandom_range(0, 1)) begin
				put(CH_COMMA); put_number(); put(CH_COMMA); put_number(); put(CH_COMMA);
				repeat ($urandom_range(0, 3)) put(any_plain(1'b0));
			end
			if ($urandom_range(0, 1)) put(CH_END);
		end else if (c < 97) begin
			// alert abandoned by a new start inside its payload
			put_text("$A");
			put_number();
			put(CH_COMMA);
			repeat ($urandom_range(0, 4)) put(any_plain(1'b0));
		end else begin
			// bytes outside any frame; the block ignores them
			n_frames--;
			repeat ($urandom_range(1, 4)) begin
				do
					t = 8'($urandom);
				while (t == CH_START);
				put(t);
			end
		end
	endtask

	// Byte source: one transaction per queued byte, random gaps with quiet stretches
	logic byte_taken = 1'b0;
	int   src_gap = 0;
	bit   src_quiet = 1'b0;

	always @(negedge clk) begin : drive_rx
		tx_item_t nxt;
		if (!arst_n)
			rx_ch.valid <= 1'b0;
		else if (!(rx_ch.valid && !byte_taken)) begin
			if (src_gap != 0) begin
				rx_ch.valid <= 1'b0;
				src_gap--;
			end else if (tx_bytes.size() != 0 &&
			             (!tx_bytes[0].hold || due_results.size() == 0)) begin
				nxt = tx_bytes.pop_front();
				rx_ch.valid <= 1'b1;
				rx_ch.rx_byte <= nxt.data;
				src_gap = src_quiet ? 0 : $urandom_range(0, 9);
				if ($urandom_range(0, 24) == 0) src_quiet = !src_quiet;
			end else
				rx_ch.valid <= 1'b0;
		end
	end

	// Result sink: random stalls per result
	int res_wait = 0;
	bit sink_quiet = 1'b0;

	always @(negedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else if (res_wait != 0) begin
			res_ch.ready <= 1'b0;
			res_wait <= res_wait - 1;
		end else
			res_ch.ready <= 1'b1;
	end

	task automatic cmp(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// Track accepted bytes, check each result against the oldest prediction
	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n) begin
			byte_taken <= rx_ch.valid && rx_ch.ready;
			if (rx_ch.valid && rx_ch.ready)
				track_byte(rx_ch.rx_byte);
			if (res_ch.valid && res_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("result kind %0d with nothing expected", res_ch.kind);
					n_errors++;
				end else begin
					want = due_results.pop_front();
					cmp("kind", want.kind, res_ch.kind);
					cmp("pos_x", want.pos_x, res_ch.pos_x);
					cmp("pos_y", want.pos_y, res_ch.pos_y);
					cmp("rotation", want.rotation, res_ch.rotation);
					cmp("cells", want.cells, res_ch.cells);
					cmp("direction", want.direction, res_ch.direction);
					cmp("alert_id", want.alert_id, res_ch.alert_id);
					cmp("payload_len", want.payload_len, res_ch.payload_len);
					cmp("payload_byte", want.payload_byte, res_ch.payload_byte);
					cmp("last", want.last, res_ch.last);
					if (want.kind <= KIND_MALFORMED) kind_seen[want.kind]++;
				end
				n_checked++;
				res_wait <= sink_quiet ? 0 : $urandom_range(0, 9);
				if ($urandom_range(0, 24) == 0) sink_quiet = !sink_quiet;
			end
		end
	end

	initial begin
		#1_000_000;
		$display("[ascii_command_frame_parser_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		res_ch.ready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: each frame type, value wrap, odd fields and tokens, broken frames
		put_text("$GOjunk,:");
		put_text("$D255,256,1000,01K2SE:");
		put_text("$Dq,/,~,,,,,:");
		put_text("$D,,,0000NWX:");
		put_text("$A300,a");
		put(8'hFF); put(8'h00); put(CH_END);
		put_text("$A7,:");
		put_text("$X:$GA:$:");
		put_text("$D1$GO:");
		put_text("$D1,2:");

		// Random frames, the first one held until the directed results are in
		hold_next = 1'b1;
		while (n_fed < 110) begin
			if ($urandom_range(0, 39) == 0) hold_next = 1'b1;
			put_frame();
			while (tx_bytes.size() > 8) @(negedge clk);
		end

		while (tx_bytes.size() != 0 || rx_ch.valid) @(negedge clk);
		while (due_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("Sent %0d frame bytes in about %0d random frames; checked %0d results",
			n_fed, n_frames, n_checked);
		$display("  go %0d, response %0d, alert %0d, payload %0d, malformed %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
		if (n_errors == 0)
			$display("[ascii_command_frame_parser_top] OK");
		else
			$display("[ascii_command_frame_parser_top] ERROR");
		$finish;
	end

endmodule
